// ----- hdl/gdr_pkg.sv -----
`default_nettype none
package gdr_pkg;

    // fixed point and map geometry
    localparam int FRAC      = 16;
    localparam int CELL_W    = 6;
    localparam int ADDR_W    = 2 * CELL_W;
    localparam int MAX_SCR   = 4096;
    localparam int DIM_W     = 13;

    localparam logic [CELL_W-1:0] CELL_LAST = '1;
    localparam logic [22:0] DIST_MAX  = 23'd8388607;
    localparam logic [22:0] DIST_MIN  = 23'd6554;
    localparam logic [14:0] LINE_MAX  = 15'd32767;

    // shared divider widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 36;

    // register map (index = paddr[4:2])
    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_SCR_W   = 3'd6;
    localparam logic [2:0] REG_SCR_H   = 3'd7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic        cell_is_wall;
        logic [11:0] column;
    } t_in_word;

    typedef struct packed {
        logic [11:0] column_out;
        logic        side;
        logic [5:0]  hit_x;
        logic [5:0]  hit_y;
        logic [22:0] wall_distance;
        logic [14:0] line_height;
        logic [11:0] draw_start;
        logic [11:0] draw_end;
        logic        escaped;
    } t_out_word;

    // live configuration as seen by the datapath
    typedef struct packed {
        logic [21:0]        pos_x;
        logic [21:0]        pos_y;
        logic signed [18:0] dir_x;
        logic signed [18:0] dir_y;
        logic signed [18:0] plane_x;
        logic signed [18:0] plane_y;
        logic [DIM_W-1:0]   scr_w;
        logic [DIM_W-1:0]   scr_h;
    } t_cfg;

endpackage
`default_nettype wire

// ----- hdl/grid_dda_raycaster_column.sv -----
`default_nettype none
// Column raycaster over a 64 x 64 wall map, fixed point with 16 fraction
// bits (position Q6.16, step distances Q16.16). Input channel (i_in_valid /
// o_in_stall, word i_in_word): a write word sets one map cell and leaves
// the input ready for the next word; a cast word walks one screen column
// and yields one result word on the output channel (o_out_valid /
// i_out_stall, word o_out_word). A cast runs on one shared 48-bit
// restoring divider (one quotient bit per cycle) used up to five times:
// camera x, the two step distances, the wall distance and the line height.
// Each DDA grid step is a map read, then a test. The input is stalled
// while a cast runs. The result sits in an output register, so the next
// word is taken while an earlier result waits for the receiver; a cast that
// ends while that register is still full waits until it has been taken.
// After reset the map is swept clear, one cell a cycle: the input is
// stalled until the sweep is done. The APB registers take writes at any
// time and reset to their listed values.
module grid_dda_raycaster_column (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gdr_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gdr_pkg::t_out_word      o_out_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    import gdr_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CAM_W, S_MULX, S_MULY, S_DX, S_DX_W, S_DY, S_DY_W,
        S_SDX, S_SDY, S_STEP, S_CHECK, S_DIST, S_DIST_W, S_LINE, S_LINE_W, S_FIN
    } t_state;

    t_cfg   w_cfg;
    t_state r_state;

    gdr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // divider
    logic              r_div_start;
    logic [DIV_NW-1:0] r_div_num;
    logic [DIV_DW-1:0] r_div_den;
    logic              w_div_done;
    logic [DIV_NW-1:0] w_quo;

    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // datapath registers
    logic [11:0]        r_col;
    logic signed [30:0] r_cam;
    logic signed [35:0] r_rx, r_ry;
    logic [31:0]        r_ddx, r_ddy, r_sdx, r_sdy;
    logic [CELL_W-1:0]  r_cx, r_cy;
    logic               r_side, r_esc;
    logic [22:0]        r_dist;
    logic [14:0]        r_line;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_ov;
    t_out_word          r_out;

    // wall map
    logic               r_map [2**ADDR_W];
    logic               r_rd_bit;
    logic               w_in_acc;
    logic [ADDR_W-1:0]  w_rd_addr;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // shared multiplier
    logic signed [18:0] w_mul_a;
    logic signed [33:0] w_mul_b;
    logic signed [52:0] w_prod;
    logic [16:0]        w_frx, w_fry;

    assign w_frx = r_rx[35] ? {1'b0, w_cfg.pos_x[15:0]}
                            : 17'h10000 - {1'b0, w_cfg.pos_x[15:0]};
    assign w_fry = r_ry[35] ? {1'b0, w_cfg.pos_y[15:0]}
                            : 17'h10000 - {1'b0, w_cfg.pos_y[15:0]};

    always_comb begin
        unique case (r_state)
            S_MULX:  begin w_mul_a = w_cfg.plane_x; w_mul_b = 34'(r_cam); end
            S_MULY:  begin w_mul_a = w_cfg.plane_y; w_mul_b = 34'(r_cam); end
            S_SDX:   begin w_mul_a = {2'b0, w_frx}; w_mul_b = {2'b0, r_ddx}; end
            default: begin w_mul_a = {2'b0, w_fry}; w_mul_b = {2'b0, r_ddy}; end
        endcase
    end
    assign w_prod = 53'(w_mul_a) * 53'(w_mul_b);

    // one DDA step
    logic              w_take_x, w_edge;
    logic [32:0]       w_sum;
    logic [CELL_W-1:0] w_nx, w_ny;

    assign w_take_x = r_sdx < r_sdy;
    assign w_sum    = w_take_x ? ({1'b0, r_sdx} + {1'b0, r_ddx})
                               : ({1'b0, r_sdy} + {1'b0, r_ddy});
    always_comb begin
        w_nx = r_cx;
        w_ny = r_cy;
        if (w_take_x) begin
            w_edge = r_rx[35] ? (r_cx == '0) : (r_cx == CELL_LAST);
            w_nx   = r_rx[35] ? r_cx - 1'b1 : r_cx + 1'b1;
        end else begin
            w_edge = r_ry[35] ? (r_cy == '0) : (r_cy == CELL_LAST);
            w_ny   = r_ry[35] ? r_cy - 1'b1 : r_cy + 1'b1;
        end
    end
    assign w_rd_addr = {w_ny, w_nx};

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR)
            r_map[r_clr_addr] <= 1'b0;
        else if (w_in_acc && i_in_word.action == ACT_WRITE)
            r_map[{i_in_word.cell_y, i_in_word.cell_x}] <= i_in_word.cell_is_wall;
        if (r_state == S_STEP)
            r_rd_bit <= r_map[w_rd_addr];
    end

    // wall distance numerator and ray
    logic signed [23:0] w_num;
    logic signed [35:0] w_ray;
    logic [22:0]        w_num_mag;
    logic [35:0]        w_ray_mag;

    always_comb begin
        if (r_side) begin
            w_num = 24'({1'b0, r_cy, 16'd0}) - 24'({1'b0, w_cfg.pos_y})
                  + (r_ry[35] ? 24'sh10000 : 24'sd0);
            w_ray = r_ry;
        end else begin
            w_num = 24'({1'b0, r_cx, 16'd0}) - 24'({1'b0, w_cfg.pos_x})
                  + (r_rx[35] ? 24'sh10000 : 24'sd0);
            w_ray = r_rx;
        end
    end
    assign w_num_mag = w_num[23] ? 23'(-w_num) : w_num[22:0];
    assign w_ray_mag = w_ray[35] ? 36'(-w_ray) : w_ray;

    logic [35:0] w_rx_mag, w_ry_mag;
    assign w_rx_mag = r_rx[35] ? 36'(-r_rx) : r_rx;
    assign w_ry_mag = r_ry[35] ? 36'(-r_ry) : r_ry;

    // draw span
    logic [11:0] w_half;
    logic [13:0] w_lh2;
    logic [14:0] w_de;
    logic [11:0] w_ds;
    assign w_half = w_cfg.scr_h[12:1];
    assign w_lh2  = r_line[14:1];
    assign w_ds   = (w_lh2 > 14'(w_half)) ? 12'd0 : 12'(14'(w_half) - w_lh2);
    assign w_de   = (15'(w_half) + 15'(w_lh2) >= 15'(w_cfg.scr_h))
                  ? 15'(w_cfg.scr_h) - 15'd1 : 15'(w_half) + 15'(w_lh2);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_ov        <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            // output word taken; a finishing cast reloads it below
            if (r_ov && !i_out_stall && r_state != S_FIN)
                r_ov <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1)
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_in_acc && i_in_word.action == ACT_CAST) begin
                        r_col       <= i_in_word.column;
                        r_esc       <= 1'b0;
                        r_div_num   <= DIV_NW'({i_in_word.column, 17'd0});
                        r_div_den   <= DIV_DW'(w_cfg.scr_w);
                        r_div_start <= 1'b1;
                        r_state     <= S_CAM_W;
                    end
                end
                S_CAM_W: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_cam   <= 31'(w_quo[28:0]) - 31'sh10000;
                        r_state <= S_MULX;
                    end
                end
                S_MULX: begin
                    r_rx    <= 36'(w_cfg.dir_x) + 36'(w_prod >>> FRAC);
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_ry    <= 36'(w_cfg.dir_y) + 36'(w_prod >>> FRAC);
                    r_state <= S_DX;
                end
                S_DX: begin
                    if (r_rx == '0) begin
                        r_ddx   <= '1;
                        r_state <= S_DY;
                    end else begin
                        r_div_num   <= DIV_NW'(1) << (2 * FRAC);
                        r_div_den   <= w_rx_mag;
                        r_div_start <= 1'b1;
                        r_state     <= S_DX_W;
                    end
                end
                S_DX_W: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_ddx   <= (w_quo[DIV_NW-1:32] != '0) ? '1 : w_quo[31:0];
                        r_state <= S_DY;
                    end
                end
                S_DY: begin
                    if (r_ry == '0) begin
                        r_ddy   <= '1;
                        r_state <= S_SDX;
                    end else begin
                        r_div_num   <= DIV_NW'(1) << (2 * FRAC);
                        r_div_den   <= w_ry_mag;
                        r_div_start <= 1'b1;
                        r_state     <= S_DY_W;
                    end
                end
                S_DY_W: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_ddy   <= (w_quo[DIV_NW-1:32] != '0) ? '1 : w_quo[31:0];
                        r_state <= S_SDX;
                    end
                end
                S_SDX: begin
                    r_sdx   <= (w_prod[52:48] != '0) ? '1 : w_prod[47:16];
                    r_cx    <= w_cfg.pos_x[21:16];
                    r_cy    <= w_cfg.pos_y[21:16];
                    r_state <= S_SDY;
                end
                S_SDY: begin
                    r_sdy   <= (w_prod[52:48] != '0) ? '1 : w_prod[47:16];
                    r_side  <= 1'b0;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (w_edge) begin
                        r_esc   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        if (w_take_x) r_sdx <= w_sum[32] ? '1 : w_sum[31:0];
                        else          r_sdy <= w_sum[32] ? '1 : w_sum[31:0];
                        r_cx    <= w_nx;
                        r_cy    <= w_ny;
                        r_side  <= !w_take_x;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= r_rd_bit ? S_DIST : S_STEP;
                end
                S_DIST: begin
                    if (w_ray == '0) begin
                        r_dist  <= DIST_MAX;
                        r_state <= S_LINE;
                    end else if ((w_num[23] != w_ray[35]) && (w_num != '0)) begin
                        r_dist  <= DIST_MIN;
                        r_state <= S_LINE;
                    end else begin
                        r_div_num   <= DIV_NW'({w_num_mag, 16'd0});
                        r_div_den   <= w_ray_mag;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIST_W;
                    end
                end
                S_DIST_W: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        priority if (w_quo == '0)
                            r_dist <= DIST_MIN;
                        else if (w_quo > DIV_NW'(DIST_MAX))
                            r_dist <= DIST_MAX;
                        else
                            r_dist <= w_quo[22:0];
                        r_state <= S_LINE;
                    end
                end
                S_LINE: begin
                    r_div_num   <= DIV_NW'({w_cfg.scr_h, 16'd0});
                    r_div_den   <= DIV_DW'({r_dist, 1'b0});
                    r_div_start <= 1'b1;
                    r_state     <= S_LINE_W;
                end
                S_LINE_W: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_line  <= (w_quo > DIV_NW'(LINE_MAX)) ? LINE_MAX : w_quo[14:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov             <= 1'b1;
                        r_out.column_out <= r_col;
                        r_out.escaped    <= r_esc;
                        if (r_esc) begin
                            r_out.side          <= 1'b0;
                            r_out.hit_x         <= '0;
                            r_out.hit_y         <= '0;
                            r_out.wall_distance <= '0;
                            r_out.line_height   <= '0;
                            r_out.draw_start    <= '0;
                            r_out.draw_end      <= '0;
                        end else begin
                            r_out.side          <= r_side;
                            r_out.hit_x         <= r_cx;
                            r_out.hit_y         <= r_cy;
                            r_out.wall_distance <= r_dist;
                            r_out.line_height   <= r_line;
                            r_out.draw_start    <= w_ds;
                            r_out.draw_end      <= w_de[11:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

// ----- hdl/gdr_regs.sv -----
`default_nettype none
module gdr_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output gdr_pkg::t_cfg      o_cfg
);
    import gdr_pkg::*;

    logic [21:0]        r_pos_x, r_pos_y;
    logic signed [18:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [DIM_W-1:0]   r_scr_w, r_scr_h;
    logic               w_wr;
    logic [2:0]         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 22'd163840;
            r_pos_y   <= 22'd163840;
            r_dir_x   <= -19'sd65536;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= 19'sd43254;
            r_scr_w   <= 13'd640;
            r_scr_h   <= 13'd480;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POS_X:   r_pos_x   <= pwdata[21:0];
                REG_POS_Y:   r_pos_y   <= pwdata[21:0];
                REG_DIR_X:   r_dir_x   <= pwdata[18:0];
                REG_DIR_Y:   r_dir_y   <= pwdata[18:0];
                REG_PLANE_X: r_plane_x <= pwdata[18:0];
                REG_PLANE_Y: r_plane_y <= pwdata[18:0];
                REG_SCR_W:   r_scr_w   <= pwdata[12:0];
                REG_SCR_H:   r_scr_h   <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_POS_X:   prdata = {10'd0, r_pos_x};
            REG_POS_Y:   prdata = {10'd0, r_pos_y};
            REG_DIR_X:   prdata = 32'(r_dir_x);
            REG_DIR_Y:   prdata = 32'(r_dir_y);
            REG_PLANE_X: prdata = 32'(r_plane_x);
            REG_PLANE_Y: prdata = 32'(r_plane_y);
            REG_SCR_W:   prdata = {19'd0, r_scr_w};
            REG_SCR_H:   prdata = {19'd0, r_scr_h};
            default:     prdata = '0;
        endcase
    end

    // screen sizes: zero used as one, clipped to the largest screen
    function automatic logic [DIM_W-1:0] dim(input logic [DIM_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (v > DIM_W'(MAX_SCR)) return DIM_W'(MAX_SCR);
        return v;
    endfunction

    always_comb begin
        o_cfg.pos_x   = r_pos_x;
        o_cfg.pos_y   = r_pos_y;
        o_cfg.dir_x   = r_dir_x;
        o_cfg.dir_y   = r_dir_y;
        o_cfg.plane_x = r_plane_x;
        o_cfg.plane_y = r_plane_y;
        o_cfg.scr_w   = dim(r_scr_w);
        o_cfg.scr_h   = dim(r_scr_h);
    end

endmodule
`default_nettype wire

// ----- hdl/gdr_div.sv -----
`default_nettype none
module gdr_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [gdr_pkg::DIV_NW-1:0]   i_num,
    input  wire logic [gdr_pkg::DIV_DW-1:0]   i_den,
    output logic                              o_done,
    output logic      [gdr_pkg::DIV_NW-1:0]   o_quo
);
    import gdr_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   w_shift;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    // restoring step: one quotient bit a cycle
    assign w_shift = {r_rem, r_num[DIV_NW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_shift[DIV_DW-1:0];
                r_num <= {r_num[DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule
`default_nettype wire
